>>> rtl/core/rwcr_pkg.sv
// Shared types and constants for the register window call/return control block.
package rwcr_pkg;

    // Default physical register count; window positions are NAREG/4
    localparam int NAREG_DEFAULT = 64;

    // Return address: top bits from pc, low bits from a0
    localparam logic [31:0] RET_PC_HI_MASK = 32'hc000_0000;
    localparam logic [31:0] RET_A0_LO_MASK = 32'h3fff_ffff;
    localparam int          RET_N_SHIFT    = 30;

    // Stream payload widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 104;

    typedef enum logic [2:0] {
        OP_ENTRY      = 3'd0,
        OP_RETURN     = 3'd1,
        OP_ROTATE     = 3'd2,
        OP_WCHECK     = 3'd3,
        OP_MOVSP      = 3'd4,
        OP_WRITE_WB   = 3'd5,
        OP_RESTORE_WB = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_ILLEGAL     = 4'd1,
        EV_ALLOCA      = 4'd2,
        EV_OVERFLOW4   = 4'd3,
        EV_OVERFLOW8   = 4'd4,
        EV_OVERFLOW12  = 4'd5,
        EV_UNDERFLOW4  = 4'd6,
        EV_UNDERFLOW8  = 4'd7,
        EV_UNDERFLOW12 = 4'd8
    } event_t;

    typedef enum logic [1:0] {
        VC_KERNEL = 2'd0,
        VC_USER   = 2'd1,
        VC_DOUBLE = 2'd2
    } vclass_t;

    // Request payload, last member in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [3:0]  ps_owb;
        logic [1:0]  ps_call_incr;
        logic        ps_um;
        logic        ps_excm;
        logic        ps_woe;
        logic [11:0] immediate;
        logic [3:0]  reg_select;
        logic [31:0] reg_value;
        logic [31:0] pc;
    } req_t;

    // Result payload, last member in the lowest bits
    typedef struct packed {
        logic [15:0] window_start_out;
        logic [3:0]  window_base_out;
        logic        pc_to_depc;
        logic [3:0]  owb_value;
        logic        owb_write;
        logic        set_excm;
        vclass_t     vector_class;
        event_t      event_res;
        logic [31:0] return_pc;
        logic [31:0] reg_write_value;
        logic [5:0]  reg_write_index;
        logic        reg_write_enable;
    } res_t;

endpackage

>>> rtl/core/rwcr_calc.sv
// Single-pass decode of one windowed instruction against window base and start mask.
module rwcr_calc #(
    parameter int NAREG = rwcr_pkg::NAREG_DEFAULT
) (
    input  rwcr_pkg::op_t                          op,
    input  rwcr_pkg::req_t                         req,
    input  logic [$clog2(NAREG/4)-1:0]             wb,
    input  logic [NAREG/4-1:0]                     ws,
    input  logic                                   has_depc,
    output rwcr_pkg::res_t                         res,
    output logic [$clog2(NAREG/4)-1:0]             wb_next,
    output logic [NAREG/4-1:0]                     ws_next
);
    import rwcr_pkg::*;

    localparam int NPOS = NAREG / 4;
    localparam int WB_W = $clog2(NPOS);

    logic            win_ok;
    logic            bit_m1, bit_m2, bit_m3;
    logic [1:0]      ret_n;
    logic            ret_mismatch;
    logic            ret_legal;
    logic [WB_W-1:0] ret_wb;
    logic [WB_W-1:0] ent_wb;
    logic [WB_W-1:0] rot_wb;
    logic [3:0]      rot_sum;
    logic            chk_found;
    logic [WB_W-1:0] chk_n;
    logic [WB_W-1:0] chk_pos;
    logic [WB_W-1:0] scan_pos;
    vclass_t         vclass;

    // Caller-frame bits below the current window
    assign win_ok = req.ps_woe && !req.ps_excm;
    assign bit_m1 = ws[wb - WB_W'(1)];
    assign bit_m2 = ws[wb - WB_W'(2)];
    assign bit_m3 = ws[wb - WB_W'(3)];

    // Return: call size from a0 must match the nearest live frame
    assign ret_n        = req.reg_value[RET_N_SHIFT +: 2];
    assign ret_mismatch = bit_m1 ? (ret_n != 2'd1) :
                          bit_m2 ? (ret_n != 2'd2) :
                          bit_m3 ? (ret_n != 2'd3) : 1'b0;
    assign ret_legal    = (ret_n != 2'd0) && !ret_mismatch && win_ok;
    assign ret_wb       = wb - WB_W'(ret_n);

    // Entry and rotate targets
    assign ent_wb  = wb + WB_W'(req.ps_call_incr);
    assign rot_sum = 4'(wb) + req.immediate[3:0];
    assign rot_wb  = rot_sum[WB_W-1:0];

    // Window check: first live frame ahead within the count, lowest distance wins
    always_comb begin
        chk_found = 1'b0;
        chk_n     = '0;
        scan_pos  = '0;
        for (int k = NPOS; k >= 1; k--) begin
            scan_pos = wb + WB_W'(k);
            if (ws[scan_pos] && (12'(k) <= req.immediate)) begin
                chk_found = 1'b1;
                chk_n     = WB_W'(k);
            end
        end
    end
    assign chk_pos = wb + chk_n;

    assign vclass = req.ps_excm ? VC_DOUBLE : (req.ps_um ? VC_USER : VC_KERNEL);

    // Result fields and next state per operation
    always_comb begin
        res     = '0;
        wb_next = wb;
        ws_next = ws;
        case (op)
            OP_ENTRY: begin
                if (req.reg_select > 4'd3 || !win_ok) begin
                    res.event_res    = EV_ILLEGAL;
                    res.set_excm     = 1'b1;
                    res.vector_class = vclass;
                    res.pc_to_depc   = req.ps_excm && has_depc;
                end else begin
                    res.reg_write_enable = 1'b1;
                    res.reg_write_index  = 6'({ent_wb, req.reg_select[1:0]});
                    res.reg_write_value  = req.reg_value - {req.immediate, 3'b000};
                    wb_next              = ent_wb;
                    ws_next              = ws | (NPOS'(1) << ent_wb);
                end
            end
            OP_RETURN: begin
                if (!ret_legal) begin
                    res.event_res    = EV_ILLEGAL;
                    res.set_excm     = 1'b1;
                    res.vector_class = vclass;
                    res.pc_to_depc   = req.ps_excm && has_depc;
                end else begin
                    res.return_pc = (req.pc & RET_PC_HI_MASK) |
                                    (req.reg_value & RET_A0_LO_MASK);
                    wb_next       = ret_wb;
                    if (ws[ret_wb]) begin
                        ws_next = ws & ~(NPOS'(1) << wb);
                    end else begin
                        case (ret_n)
                            2'd1:    res.event_res = EV_UNDERFLOW4;
                            2'd2:    res.event_res = EV_UNDERFLOW8;
                            default: res.event_res = EV_UNDERFLOW12;
                        endcase
                        res.set_excm  = 1'b1;
                        res.owb_write = 1'b1;
                        res.owb_value = 4'(wb);
                    end
                end
            end
            OP_ROTATE: begin
                wb_next = rot_wb;
            end
            OP_WCHECK: begin
                if (win_ok && chk_found) begin
                    wb_next       = chk_pos;
                    res.set_excm  = 1'b1;
                    res.owb_write = 1'b1;
                    res.owb_value = 4'(wb);
                    if (ws[chk_pos + WB_W'(1)]) begin
                        res.event_res = EV_OVERFLOW4;
                    end else if (ws[chk_pos + WB_W'(2)]) begin
                        res.event_res = EV_OVERFLOW8;
                    end else begin
                        res.event_res = EV_OVERFLOW12;
                    end
                end
            end
            OP_MOVSP: begin
                if (!(bit_m1 || bit_m2 || bit_m3)) begin
                    res.event_res    = EV_ALLOCA;
                    res.set_excm     = 1'b1;
                    res.vector_class = vclass;
                    res.pc_to_depc   = req.ps_excm && has_depc;
                end
            end
            OP_WRITE_WB: begin
                wb_next = req.immediate[WB_W-1:0];
            end
            OP_RESTORE_WB: begin
                wb_next = req.ps_owb[WB_W-1:0];
            end
            default: begin
                wb_next = wb;
            end
        endcase
        res.window_base_out  = 4'(wb_next);
        res.window_start_out = 16'(ws_next);
    end

endmodule

>>> rtl/core/register_window_call_return_control.sv
// Top level of the register window call/return control block.
//
//   Channel  | Handshake                      | Payload
//   ---------+--------------------------------+----------------------------------------
//   request  | s_axis_tvalid / s_axis_tready  | s_axis_tuser operation, s_axis_tdata rest
//   result   | m_axis_tvalid / m_axis_tready  | m_axis_tdata, one result per request
//   config   | cfg_wr_en                      | cfg_wr_data = has_depc
//
// One request per cycle unless a result stalls; its result appears next cycle from the
// output register. Window base and start mask update at the accepting edge, so
// the next request sees them at once. A stalled result holds the output register;
// a new request is taken in the same cycle the held result is taken.
// Synchronous active-low reset: window base 0, start mask bit 0, has_depc set.
module register_window_call_return_control #(
    parameter int NAREG = rwcr_pkg::NAREG_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // low to high: pc[31:0], reg_value[63:32], reg_select[67:64], immediate[79:68],
    // ps_woe[80], ps_excm[81], ps_um[82], ps_call_incr[84:83], ps_owb[88:85], zero
    input  logic [rwcr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [rwcr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // low to high: reg_write_enable[0], reg_write_index[6:1], reg_write_value[38:7],
    // return_pc[70:39], event_res[74:71], vector_class[76:75], set_excm[77],
    // owb_write[78], owb_value[82:79], pc_to_depc[83], window_base_out[87:84],
    // window_start_out[103:88]
    output logic [rwcr_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import rwcr_pkg::*;

    localparam int NPOS = NAREG / 4;
    localparam int WB_W = $clog2(NPOS);

    logic [WB_W-1:0] wb_reg, wb_next;
    logic [NPOS-1:0] ws_reg, ws_next;
    logic            has_depc_reg;
    logic            m_tvalid_reg;
    res_t            m_tdata_reg;
    res_t            res_calc;
    logic            s_accept;

    assign s_axis_tready = aresetn && (!m_tvalid_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    rwcr_calc #(
        .NAREG (NAREG)
    ) u_calc (
        .op       (op_t'(s_axis_tuser)),
        .req      (req_t'(s_axis_tdata)),
        .wb       (wb_reg),
        .ws       (ws_reg),
        .has_depc (has_depc_reg),
        .res      (res_calc),
        .wb_next  (wb_next),
        .ws_next  (ws_next)
    );

    // Advance window state on each accepted request; take config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg       <= '0;
            ws_reg       <= NPOS'(1);
            has_depc_reg <= 1'b1;
        end else begin
            if (s_accept) begin
                wb_reg <= wb_next;
                ws_reg <= ws_next;
            end
            if (cfg_wr_en) begin
                has_depc_reg <= cfg_wr_data;
            end
        end
    end

    // Output register: load on accept, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= res_calc;
        end
    end

`ifndef SYNTHESIS
    // Some window always stays marked live
    assert property (@(posedge aclk) disable iff (!aresetn) ws_reg != '0)
        else $error("window start mask became empty");

    // Window state only moves with an accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !s_accept) |=> ($stable(wb_reg) && $stable(ws_reg)))
        else $error("window state changed without a request");

    // Old-base write goes with spill events only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg.owb_write ==
            (m_tdata_reg.event_res != EV_NONE && m_tdata_reg.event_res != EV_ILLEGAL &&
             m_tdata_reg.event_res != EV_ALLOCA)))
        else $error("old base write does not match event");

    // A register write never comes with an event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg.reg_write_enable) |->
            (m_tdata_reg.event_res == EV_NONE && !m_tdata_reg.set_excm))
        else $error("register write together with an event");

    // Result shows the window base the state register holds after its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_accept) |=> (m_tdata_reg.window_base_out == 4'(wb_reg)))
        else $error("reported window base differs from state");
`endif

endmodule
